// ===== src/pilot_phase_estimate_derotate_macros.svh =====
// Assertion macros shared by the checker of the phase estimator.
`ifndef PILOT_PHASE_ESTIMATE_DEROTATE_MACROS_SVH
`define PILOT_PHASE_ESTIMATE_DEROTATE_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define PPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check with the consequent in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ppe_pkg.sv =====
// Package with types, constants and helper functions of the phase estimator.
package ppe_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 16;
	localparam int ACC_W    = 43;
	localparam int CX_W     = 46;
	localparam int Z_W      = 34;
	localparam int STEPS    = 30;
	localparam int PROD_W   = 2 * SAMPLE_W + 1;
	localparam int RX_W     = 28;
	localparam int RMUL_W   = 52;
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;
	localparam logic [16:0] GAIN_ONE = 17'd32768;

	// Operation codes carried in the input kind field.
	typedef enum logic [1:0] {
		OP_PILOT = 2'd0,
		OP_LAST  = 2'd1,
		OP_ROT   = 2'd2,
		OP_PASS  = 2'd3
	} op_t;

	// Kind of work handed from the front to the back.
	typedef enum logic [1:0] {
		JOB_VEC  = 2'd0,
		JOB_ROT  = 2'd1,
		JOB_PASS = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [ACC_W-1:0]  x;
		logic [ACC_W-1:0]  y;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SETUP,
		B_ITER,
		B_VDIFF,
		B_VMUL,
		B_VUPD,
		B_RMUL,
		B_RSAT,
		B_EMIT
	} back_state_t;

	// Arctangent of 2^-k as a 32-bit binary angle.
	function automatic logic [31:0] atan_val(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Saturate a 44-bit sum into the 43-bit accumulator range.
	function automatic logic [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
		logic [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	// Saturate a 20-bit value to the sample range.
	function automatic logic [SAMPLE_W-1:0] sat_smp(input logic signed [19:0] v);
		logic [SAMPLE_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'h7fff;
		end else if (v < -20'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/pilot_phase_estimate_derotate.sv =====
// Top level of the pilot-aided phase estimator and derotator.
// Pilot requests are correlated at one per cycle in the front end, unless a
// non-pilot request ahead of them waits for a queue slot, and give no result.
// A last pilot, a rotate or a pass request is queued for the back end. The back
// end handles one request at a time with the 30-step CORDIC, which it iterates once per cycle:
//   - a pass request goes straight to the result stage;
//   - a rotation runs setup, the CORDIC steps, gain removal and saturation;
//   - a phase update runs setup, the CORDIC steps, then the loop difference,
//     multiply and update, skipping the steps when the sum lies on the real axis.
// A stalled result holds the back end until it is taken. A two-entry queue lets
// pilots keep streaming while the back end works, and the output register holds
// a result until taken.
module pilot_phase_estimate_derotate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_i, sample_q, ref_i, ref_q
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_i, out_q, phase_est
	output logic        m_tuser,   // is_phase_update
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic          job_valid;
	logic          job_ready;
	ppe_pkg::job_t job;
	logic          q_valid;
	logic          q_ready;
	ppe_pkg::job_t q_job;
	logic [15:0]   loop_gain_q;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {16'h0000, loop_gain_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_gain_q <= 16'd16384;
		end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
			loop_gain_q <= pwdata[15:0];
		end
	end

	ppe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_si     (s_tdata[15:0]),
		.in_sq     (s_tdata[31:16]),
		.in_ri     (s_tdata[47:32]),
		.in_rq     (s_tdata[63:48]),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	ppe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_ready (job_ready),
		.wr_job   (job),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_job   (q_job)
	);

	ppe_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (q_valid),
		.job_ready       (q_ready),
		.job             (q_job),
		.loop_gain       (loop_gain_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_i           (m_tdata[15:0]),
		.out_q           (m_tdata[31:16]),
		.phase_est       (m_tdata[47:32]),
		.is_phase_update (m_tuser)
	);

endmodule

// ===== src/ppe_front.sv =====
// Front end: correlates pilots, classifies items and queues work for the back end.
module ppe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_op,
	input  logic [ppe_pkg::SAMPLE_W-1:0]  in_si,
	input  logic [ppe_pkg::SAMPLE_W-1:0]  in_sq,
	input  logic [ppe_pkg::SAMPLE_W-1:0]  in_ri,
	input  logic [ppe_pkg::SAMPLE_W-1:0]  in_rq,
	output logic                          job_valid,
	input  logic                          job_ready,
	output ppe_pkg::job_t                 job
);

	logic                               v_s1;
	logic                               v_s2;
	logic [1:0]                         op_s1;
	logic [1:0]                         op_s2;
	logic signed [ppe_pkg::SAMPLE_W-1:0] si_s1;
	logic signed [ppe_pkg::SAMPLE_W-1:0] sq_s1;
	logic signed [ppe_pkg::SAMPLE_W-1:0] si_s2;
	logic signed [ppe_pkg::SAMPLE_W-1:0] sq_s2;
	logic signed [ppe_pkg::SAMPLE_W-1:0] ri_s1;
	logic signed [ppe_pkg::SAMPLE_W-1:0] rq_s1;
	logic signed [2*ppe_pkg::SAMPLE_W-1:0] p_ii_s2;
	logic signed [2*ppe_pkg::SAMPLE_W-1:0] p_qq_s2;
	logic signed [2*ppe_pkg::SAMPLE_W-1:0] p_qi_s2;
	logic signed [2*ppe_pkg::SAMPLE_W-1:0] p_iq_s2;
	logic signed [ppe_pkg::ACC_W-1:0]    re_q;
	logic signed [ppe_pkg::ACC_W-1:0]    im_q;
	logic signed [ppe_pkg::PROD_W-1:0]   term_re;
	logic signed [ppe_pkg::PROD_W-1:0]   term_im;
	logic [ppe_pkg::ACC_W-1:0]           re_next;
	logic [ppe_pkg::ACC_W-1:0]           im_next;
	logic                               push;
	logic                               advance;

	// A non-pilot item in the last stage needs a queue slot to move on.
	assign push     = v_s2 && (op_s2 != ppe_pkg::OP_PILOT);
	assign advance  = !push || job_ready;
	assign in_ready = advance;

	// Correlation terms and saturating sums.
	assign term_re = ppe_pkg::PROD_W'(p_ii_s2) + ppe_pkg::PROD_W'(p_qq_s2);
	assign term_im = ppe_pkg::PROD_W'(p_qi_s2) - ppe_pkg::PROD_W'(p_iq_s2);
	assign re_next = ppe_pkg::sat_acc((ppe_pkg::ACC_W+1)'(re_q) + (ppe_pkg::ACC_W+1)'(term_re));
	assign im_next = ppe_pkg::sat_acc((ppe_pkg::ACC_W+1)'(im_q) + (ppe_pkg::ACC_W+1)'(term_im));

	// Job toward the back end.
	always_comb begin
		job_valid = push;
		job.kind  = ppe_pkg::JOB_PASS;
		job.x     = ppe_pkg::ACC_W'(si_s2);
		job.y     = ppe_pkg::ACC_W'(sq_s2);
		unique case (op_s2)
			ppe_pkg::OP_LAST: begin
				job.kind = ppe_pkg::JOB_VEC;
				job.x    = re_next;
				job.y    = im_next;
			end
			ppe_pkg::OP_ROT:  job.kind = ppe_pkg::JOB_ROT;
			default:          job.kind = ppe_pkg::JOB_PASS;
		endcase
	end

	// Pipeline valid bits and correlation sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			re_q <= '0;
			im_q <= '0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2 && op_s2 == ppe_pkg::OP_PILOT) begin
				re_q <= re_next;
				im_q <= im_next;
			end else if (v_s2 && op_s2 == ppe_pkg::OP_LAST) begin
				re_q <= '0;
				im_q <= '0;
			end
		end
	end

	// Payload stages: capture, then products.
	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1   <= in_op;
			si_s1   <= in_si;
			sq_s1   <= in_sq;
			ri_s1   <= in_ri;
			rq_s1   <= in_rq;
			op_s2   <= op_s1;
			si_s2   <= si_s1;
			sq_s2   <= sq_s1;
			p_ii_s2 <= si_s1 * ri_s1;
			p_qq_s2 <= sq_s1 * rq_s1;
			p_qi_s2 <= sq_s1 * ri_s1;
			p_iq_s2 <= si_s1 * rq_s1;
		end
	end

endmodule

// ===== src/ppe_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module ppe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  ppe_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output ppe_pkg::job_t rd_job
);

	ppe_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== src/ppe_back.sv =====
// Back end: shared CORDIC for angle and rotation, phase loop and result register.
module ppe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  ppe_pkg::job_t                 job,
	input  logic [15:0]                   loop_gain,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ppe_pkg::SAMPLE_W-1:0]  out_i,
	output logic [ppe_pkg::SAMPLE_W-1:0]  out_q,
	output logic [ppe_pkg::PHASE_W-1:0]   phase_est,
	output logic                          is_phase_update
);

	ppe_pkg::back_state_t state_q;
	ppe_pkg::back_state_t state_d;

	logic                                vec_q;
	logic signed [ppe_pkg::CX_W-1:0]     x_q;
	logic signed [ppe_pkg::CX_W-1:0]     y_q;
	logic signed [ppe_pkg::Z_W-1:0]      z_q;
	logic [4:0]                          k_q;
	logic [ppe_pkg::PHASE_W-1:0]         phase_q;
	logic signed [ppe_pkg::PHASE_W:0]    d_q;
	logic [16:0]                         g_q;
	logic signed [ppe_pkg::PROD_W+1:0]   prod_q;
	logic signed [ppe_pkg::RMUL_W-1:0]   mx_q;
	logic signed [ppe_pkg::RMUL_W-1:0]   my_q;
	logic [ppe_pkg::SAMPLE_W-1:0]        res_i_q;
	logic [ppe_pkg::SAMPLE_W-1:0]        res_q_q;
	logic [ppe_pkg::PHASE_W-1:0]         res_ph_q;
	logic                                res_upd_q;
	logic                                out_valid_q;
	logic                                out_free;

	logic signed [ppe_pkg::CX_W-1:0]     dx;
	logic signed [ppe_pkg::CX_W-1:0]     dy;
	logic                                up;
	logic signed [ppe_pkg::Z_W-1:0]      atan_z;
	logic signed [ppe_pkg::CX_W-1:0]     jx;
	logic signed [ppe_pkg::CX_W-1:0]     jy;
	logic signed [ppe_pkg::Z_W-1:0]      rz;
	logic [31:0]                         zr;
	logic [ppe_pkg::PHASE_W-1:0]         raw;
	logic [ppe_pkg::PHASE_W-1:0]         dw;
	logic signed [ppe_pkg::PROD_W+1:0]   step_full;
	logic signed [ppe_pkg::RMUL_W-1:0]   rx_full;
	logic signed [ppe_pkg::RMUL_W-1:0]   ry_full;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// One CORDIC micro-rotation per cycle.
	assign dx     = y_q >>> k_q;
	assign dy     = x_q >>> k_q;
	assign up     = vec_q ? (y_q > 0) : (z_q < 0);
	assign atan_z = ppe_pkg::Z_W'(ppe_pkg::atan_val(k_q));

	// Operands taken from the queue, and the negated phase estimate as start angle.
	assign jx = ppe_pkg::CX_W'($signed(job.x));
	assign jy = ppe_pkg::CX_W'($signed(job.y));
	assign rz = ppe_pkg::Z_W'($signed({16'(-phase_q), 16'h0000}));

	// Angle rounding and shortest step toward it.
	assign zr  = z_q[31:0] + 32'h0000_8000;
	assign raw = zr[31:16];
	assign dw  = raw - phase_q;
	assign step_full = prod_q + (ppe_pkg::PROD_W+2)'(16384);

	// Gain removal with rounding.
	assign rx_full = mx_q + (ppe_pkg::RMUL_W)'(64'sh8000_0000);
	assign ry_full = my_q + (ppe_pkg::RMUL_W)'(64'sh8000_0000);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppe_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue pop.
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		unique case (state_q)
			ppe_pkg::B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = (job.kind == ppe_pkg::JOB_PASS) ? ppe_pkg::B_EMIT
						: ppe_pkg::B_SETUP;
				end
			end
			ppe_pkg::B_SETUP: begin
				state_d = (vec_q && y_q == 0) ? ppe_pkg::B_VDIFF : ppe_pkg::B_ITER;
			end
			ppe_pkg::B_ITER: begin
				if (k_q == 5'(ppe_pkg::STEPS - 1)) begin
					state_d = vec_q ? ppe_pkg::B_VDIFF : ppe_pkg::B_RMUL;
				end
			end
			ppe_pkg::B_VDIFF: state_d = ppe_pkg::B_VMUL;
			ppe_pkg::B_VMUL:  state_d = ppe_pkg::B_VUPD;
			ppe_pkg::B_VUPD:  state_d = ppe_pkg::B_EMIT;
			ppe_pkg::B_RMUL:  state_d = ppe_pkg::B_RSAT;
			ppe_pkg::B_RSAT:  state_d = ppe_pkg::B_EMIT;
			ppe_pkg::B_EMIT: begin
				if (out_free) state_d = ppe_pkg::B_IDLE;
			end
			default: state_d = ppe_pkg::B_IDLE;
		endcase
	end

	// Phase estimate and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ppe_pkg::B_VUPD) begin
				phase_q <= phase_q + step_full[ppe_pkg::PHASE_W+14:15];
			end
			if (state_q == ppe_pkg::B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath of the shared unit.
	always_ff @(posedge clk) begin
		case (state_q)
			ppe_pkg::B_IDLE: begin
				vec_q     <= (job.kind == ppe_pkg::JOB_VEC);
				x_q       <= jx;
				y_q       <= jy;
				z_q       <= rz;
				k_q       <= '0;
				res_i_q   <= job.x[ppe_pkg::SAMPLE_W-1:0];
				res_q_q   <= job.y[ppe_pkg::SAMPLE_W-1:0];
				res_ph_q  <= phase_q;
				res_upd_q <= 1'b0;
			end
			ppe_pkg::B_SETUP: begin
				if (vec_q) begin
					// Left half plane is folded over with a half turn.
					if (x_q < 0) begin
						x_q <= -x_q;
						y_q <= -y_q;
						z_q <= ppe_pkg::Z_W'(34'h0_8000_0000);
					end else begin
						z_q <= '0;
					end
				end else begin
					// Samples get eight fraction bits; large angles are folded.
					if (z_q > ppe_pkg::Z_W'(34'sh0_4000_0000)
							|| z_q < -ppe_pkg::Z_W'(34'sh0_4000_0000)) begin
						x_q <= -(x_q <<< 8);
						y_q <= -(y_q <<< 8);
						z_q <= (z_q > 0) ? z_q - ppe_pkg::Z_W'(34'sh0_8000_0000)
							: z_q + ppe_pkg::Z_W'(34'sh0_8000_0000);
					end else begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end
				end
			end
			ppe_pkg::B_ITER: begin
				if (up) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end
				k_q <= k_q + 5'd1;
			end
			ppe_pkg::B_VDIFF: begin
				d_q <= (dw > 16'd32768) ? $signed({1'b1, dw}) : $signed({1'b0, dw});
				g_q <= ({1'b0, loop_gain} > ppe_pkg::GAIN_ONE) ? ppe_pkg::GAIN_ONE
					: {1'b0, loop_gain};
			end
			ppe_pkg::B_VMUL: begin
				prod_q <= (ppe_pkg::PROD_W+2)'(d_q * $signed({1'b0, g_q}));
			end
			ppe_pkg::B_VUPD: begin
				res_i_q   <= '0;
				res_q_q   <= '0;
				res_ph_q  <= phase_q + step_full[ppe_pkg::PHASE_W+14:15];
				res_upd_q <= 1'b1;
			end
			ppe_pkg::B_RMUL: begin
				mx_q <= ppe_pkg::RMUL_W'($signed(x_q[ppe_pkg::RX_W-1:0])
					* $signed({1'b0, ppe_pkg::GAIN_Q24}));
				my_q <= ppe_pkg::RMUL_W'($signed(y_q[ppe_pkg::RX_W-1:0])
					* $signed({1'b0, ppe_pkg::GAIN_Q24}));
			end
			ppe_pkg::B_RSAT: begin
				res_i_q <= ppe_pkg::sat_smp(rx_full[51:32]);
				res_q_q <= ppe_pkg::sat_smp(ry_full[51:32]);
			end
			default: begin
			end
		endcase
	end

	// Output register, loaded when no result is held or the held one has been taken.
	always_ff @(posedge clk) begin
		if (state_q == ppe_pkg::B_EMIT && out_free) begin
			out_i           <= res_i_q;
			out_q           <= res_q_q;
			phase_est       <= res_ph_q;
			is_phase_update <= res_upd_q;
		end
	end

endmodule

// ===== src/ppe_checker.sv =====
// Port-level checker of the phase estimator and its bind to the top level.
`include "pilot_phase_estimate_derotate_macros.svh"

module ppe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// A phase report carries a zero symbol.
	`PPE_ASSERT(a_update_zero, (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'h0), "phase report with nonzero symbol")
	// A stalled result stays offered.
	`PPE_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	// A stalled result keeps its payload.
	`PPE_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	// The gain register reads back what was written.
	`PPE_ASSERT_NEXT(a_gain_readback, psel && penable && pwrite && paddr == 3'd0, prdata[15:0] == $past(pwdata[15:0]), "gain register readback mismatch")

endmodule

bind pilot_phase_estimate_derotate ppe_checker u_ppe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
